### design/lio_pkg.sv
// Package for the legacy I/O block: field widths, function and port codes.
// No dependencies.
package lio_pkg;
    localparam int NumCountersDef = 3;
    localparam int RtcBytes = 10;
    localparam logic [15:0] RtcIntervalReset = 16'd1165;
    localparam logic [7:0] StatusAReset = 8'h26;
    localparam logic [7:0] StatusBReset = 8'h46;

    localparam logic [2:0] FuncRead  = 3'd0;
    localparam logic [2:0] FuncWrite = 3'd1;
    localparam logic [2:0] FuncPost  = 3'd2;
    localparam logic [2:0] FuncClear = 3'd3;
    localparam logic [2:0] FuncTick  = 3'd4;

    localparam logic [3:0] PortMask1 = 4'd0;
    localparam logic [3:0] PortMask2 = 4'd1;
    localparam logic [3:0] PortIsr1  = 4'd2;
    localparam logic [3:0] PortIsr2  = 4'd3;
    localparam logic [3:0] PortAck1  = 4'd4;
    localparam logic [3:0] PortCnt0  = 4'd5;
    localparam logic [3:0] PortCnt1  = 4'd6;
    localparam logic [3:0] PortCnt2  = 4'd7;
    localparam logic [3:0] PortCtrl  = 4'd8;
    localparam logic [3:0] PortIndex = 4'd9;
    localparam logic [3:0] PortData  = 4'd10;
    localparam logic [3:0] PortB     = 4'd11;
    localparam logic [3:0] PortIgn   = 4'd12;

    localparam logic [3:0] IdxStatA = 4'd10;
    localparam logic [3:0] IdxStatB = 4'd11;

    typedef struct packed {
        logic [2:0] func;
        logic [3:0] port;
        logic [7:0] wdata;
        logic [7:0] irq_bits;
    } t_req;

    typedef struct packed {
        logic [7:0] rdata;
        logic       irq_line;
        logic       rtc_irq;
        logic       access_error;
    } t_rsp;
endpackage

### design/lio_if.sv
// Valid/ready channel interfaces for the legacy I/O block.
// Depends on lio_pkg.
interface lio_req_if;
    logic valid;
    logic ready;
    lio_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lio_rsp_if;
    logic valid;
    logic ready;
    lio_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface lio_cfg_if;
    logic valid;
    logic ready;
    logic [15:0] data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

### design/legacy_io_pic_pit_rtc_block.sv
// Top level of the legacy I/O block: interrupt latch, interval counters, clock chip.
// Depends on lio_pkg and the channel interfaces in lio_if.sv.
//
//  channel | dir | payload                              | word accepted when
//  i_req   | in  | func, port, wdata, irq_bits          | valid && ready
//  o_rsp   | out | rdata, irq_line, rtc_irq, access_err | valid && ready
//  i_cfg   | in  | rtc_interval (16 bits)               | valid && ready
//
// Each word is processed in the cycle it is accepted: all state updates
// in one pass and the result lands in a single output register, so one word
// per cycle is sustained while results are taken; the result is visible in
// the next cycle. The request side is ready whenever the output register is
// empty or is being drained in the same cycle, so a stalled sink only stalls
// after one word is held. Reset is synchronous, active low.
module legacy_io_pic_pit_rtc_block #(
    parameter int NUM_COUNTERS = lio_pkg::NumCountersDef
) (
    input  logic i_clk,
    input  logic i_rst_n,
    lio_req_if.sink   i_req,
    lio_rsp_if.source o_rsp,
    lio_cfg_if.sink   i_cfg
);
    localparam int NC = NUM_COUNTERS;

    logic [15:0] r_interval;
    logic [7:0]  r_pending, r_enabled, r_mask2;
    logic [15:0] r_cval [NC], r_clat [NC], r_crem [NC];
    logic [NC-1:0] r_armed, r_out, r_lon, r_rhi, r_whi, r_mode0;
    logic [3:0]  r_index;
    logic [7:0]  r_bytes [lio_pkg::RtcBytes];
    logic [7:0]  r_sta, r_stb;
    logic [15:0] r_cd;
    logic        r_ovalid;
    lio_pkg::t_rsp r_rsp;

    // Next-state copies.
    logic [7:0]  n_pending, n_enabled, n_mask2;
    logic [15:0] n_cval [NC], n_clat [NC], n_crem [NC];
    logic [NC-1:0] n_armed, n_out, n_lon, n_rhi, n_whi, n_mode0;
    logic [3:0]  n_index;
    logic [7:0]  n_byte;
    logic        n_bwr;
    logic [7:0]  n_sta, n_stb;
    logic [15:0] n_cd;
    lio_pkg::t_rsp n_rsp;

    logic acc;
    lio_pkg::t_req q;

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_ovalid || o_rsp.ready;
    assign acc = i_req.valid && i_req.ready;
    assign q = i_req.data;
    assign o_rsp.valid = r_ovalid;
    assign o_rsp.data = r_rsp;

    always_comb begin
        logic err;
        logic fired;
        logic [7:0] rd;
        logic [1:0] sel;
        logic [1:0] rw;
        logic [2:0] md;
        logic [15:0] v;
        logic [3:0] cidx;
        n_pending = r_pending;
        n_enabled = r_enabled;
        n_mask2   = r_mask2;
        n_cval = r_cval;
        n_clat = r_clat;
        n_crem = r_crem;
        n_armed = r_armed;
        n_out = r_out;
        n_lon = r_lon;
        n_rhi = r_rhi;
        n_whi = r_whi;
        n_mode0 = r_mode0;
        n_index = r_index;
        n_byte = q.wdata;
        n_bwr = 1'b0;
        n_sta = r_sta;
        n_stb = r_stb;
        n_cd = r_cd;
        err = 1'b0;
        fired = 1'b0;
        rd = 8'h00;
        sel = q.wdata[7:6];
        rw = q.wdata[5:4];
        md = q.wdata[3:1];
        cidx = q.port - lio_pkg::PortCnt0;
        v = 16'h0000;
        case (q.func)
            lio_pkg::FuncRead: begin
                case (q.port)
                    lio_pkg::PortMask1: rd = ~r_enabled;
                    lio_pkg::PortMask2: rd = r_mask2;
                    lio_pkg::PortIsr1:  rd = r_pending;
                    lio_pkg::PortIsr2:  rd = 8'h00;
                    lio_pkg::PortCnt0, lio_pkg::PortCnt1, lio_pkg::PortCnt2: begin
                        if (32'(cidx) < NC) begin
                            for (int c = 0; c < NC; c++) begin
                                if (32'(cidx) == c) begin
                                    v = r_lon[c] ? r_clat[c] : r_cval[c];
                                    if (r_rhi[c]) begin
                                        rd = v[15:8];
                                        n_rhi[c] = 1'b0;
                                        n_lon[c] = 1'b0;
                                    end else begin
                                        rd = v[7:0];
                                        n_rhi[c] = 1'b1;
                                    end
                                end
                            end
                        end else begin
                            err = 1'b1;
                        end
                    end
                    lio_pkg::PortData: begin
                        if (r_index < 4'(lio_pkg::RtcBytes)) begin
                            rd = r_bytes[r_index];
                        end else if (r_index == lio_pkg::IdxStatA) begin
                            n_sta = {~r_sta[7], r_sta[6:0]};
                            rd = n_sta;
                        end else if (r_index == lio_pkg::IdxStatB) begin
                            rd = r_stb;
                        end
                    end
                    lio_pkg::PortB: rd = (NC > 2 && r_out[NC-1]) ? 8'h20 : 8'h00;
                    default: err = 1'b1;
                endcase
            end
            lio_pkg::FuncWrite: begin
                case (q.port)
                    lio_pkg::PortMask1: n_enabled = ~q.wdata;
                    lio_pkg::PortMask2: n_mask2 = q.wdata;
                    lio_pkg::PortAck1: begin
                        if (!q.wdata[3]) n_pending[q.wdata[2:0]] = 1'b0;
                    end
                    lio_pkg::PortCnt0, lio_pkg::PortCnt1, lio_pkg::PortCnt2: begin
                        if (32'(cidx) < NC) begin
                            for (int c = 0; c < NC; c++) begin
                                if (32'(cidx) == c) begin
                                    if (!r_whi[c]) begin
                                        n_cval[c] = {r_cval[c][15:8], q.wdata};
                                        n_armed[c] = 1'b0;
                                        n_out[c] = 1'b0;
                                        n_whi[c] = 1'b1;
                                    end else begin
                                        n_cval[c] = {q.wdata, r_cval[c][7:0]};
                                        n_crem[c] = n_cval[c];
                                        if (n_cval[c] != 16'h0000) n_armed[c] = 1'b1;
                                        n_whi[c] = 1'b0;
                                    end
                                end
                            end
                        end else begin
                            err = 1'b1;
                        end
                    end
                    lio_pkg::PortCtrl: begin
                        if (sel == 2'd3 || 32'(sel) >= NC) begin
                            err = 1'b1;
                        end else if (rw == 2'd0) begin
                            for (int c = 0; c < NC; c++) begin
                                if (32'(sel) == c && !r_lon[c]) begin
                                    n_lon[c] = 1'b1;
                                    n_rhi[c] = 1'b0;
                                    n_clat[c] = r_cval[c];
                                end
                            end
                        end else if (rw != 2'd3 || !(md == 3'd0 || md == 3'd2 || md == 3'd3)
                                     || q.wdata[0]) begin
                            err = 1'b1;
                        end else begin
                            // Only "mode is zero" affects behavior.
                            for (int c = 0; c < NC; c++) begin
                                if (32'(sel) == c) n_mode0[c] = (md == 3'd0);
                            end
                        end
                    end
                    lio_pkg::PortIndex: begin
                        if (q.wdata <= 8'd13) n_index = q.wdata[3:0];
                        else err = 1'b1;
                    end
                    lio_pkg::PortData: begin
                        if (r_index < 4'(lio_pkg::RtcBytes)) begin
                            n_bwr = 1'b1;
                        end else if (r_index == lio_pkg::IdxStatA) begin
                            if (q.wdata != lio_pkg::StatusAReset) err = 1'b1;
                            else n_sta = q.wdata;
                        end else if (r_index == lio_pkg::IdxStatB) begin
                            if ((q.wdata & 8'hB7) != 8'h06) begin
                                err = 1'b1;
                            end else begin
                                if (q.wdata[6] && !r_stb[6]) n_cd = r_interval;
                                n_stb = q.wdata;
                            end
                        end else begin
                            err = 1'b1;
                        end
                    end
                    lio_pkg::PortB, lio_pkg::PortIgn: ;
                    default: err = 1'b1;
                endcase
            end
            lio_pkg::FuncPost:  n_pending = r_pending | q.irq_bits;
            lio_pkg::FuncClear: n_pending = r_pending & ~q.irq_bits;
            lio_pkg::FuncTick: begin
                for (int c = 0; c < NC; c++) begin
                    if (r_armed[c]) begin
                        n_crem[c] = r_crem[c] - 16'd1;
                        if (n_crem[c] == 16'h0000) begin
                            n_armed[c] = 1'b0;
                            if (r_mode0[c]) n_out[c] = 1'b1;
                        end
                    end
                end
                if (r_stb[6]) begin
                    if (r_cd <= 16'd1) begin
                        fired = 1'b1;
                        n_cd = r_interval;
                    end else begin
                        n_cd = r_cd - 16'd1;
                    end
                end
            end
            default: err = 1'b1;
        endcase
        n_rsp.rdata = err ? 8'h00 : rd;
        n_rsp.irq_line = |(n_pending & n_enabled);
        n_rsp.rtc_irq = fired;
        n_rsp.access_error = err;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_interval <= lio_pkg::RtcIntervalReset;
            r_pending <= '0;
            r_enabled <= '0;
            r_mask2 <= '0;
            for (int c = 0; c < NC; c++) begin
                r_cval[c] <= '0;
                r_clat[c] <= '0;
                r_crem[c] <= '0;
            end
            r_armed <= '0;
            r_out <= '0;
            r_lon <= '0;
            r_rhi <= '0;
            r_whi <= '0;
            r_mode0 <= '1;
            r_index <= '0;
            for (int b = 0; b < lio_pkg::RtcBytes; b++) r_bytes[b] <= '0;
            r_sta <= lio_pkg::StatusAReset;
            r_stb <= lio_pkg::StatusBReset;
            r_cd <= lio_pkg::RtcIntervalReset;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg.valid) r_interval <= i_cfg.data;
            if (acc) begin
                r_pending <= n_pending;
                r_enabled <= n_enabled;
                r_mask2 <= n_mask2;
                r_cval <= n_cval;
                r_clat <= n_clat;
                r_crem <= n_crem;
                r_armed <= n_armed;
                r_out <= n_out;
                r_lon <= n_lon;
                r_rhi <= n_rhi;
                r_whi <= n_whi;
                r_mode0 <= n_mode0;
                r_index <= n_index;
                if (n_bwr) r_bytes[r_index] <= n_byte;
                r_sta <= n_sta;
                r_stb <= n_stb;
                r_cd <= n_cd;
            end
            if (acc) r_ovalid <= 1'b1;
            else if (o_rsp.ready) r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (acc) r_rsp <= n_rsp;
    end
endmodule

### design/lio_checker.sv
// Port-level checker for the legacy I/O block, bound to the top level.
// Depends on lio_pkg and the channel interfaces.
module lio_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic req_valid,
    input logic req_ready,
    input logic rsp_valid,
    input logic rsp_ready,
    input lio_pkg::t_rsp rsp
);
    // Every accepted word gives a result on the next cycle.
    a_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        req_valid && req_ready |=> rsp_valid) else $error("missing result");
    // A refused access returns zero data.
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp.access_error |-> rsp.rdata == 8'h00) else $error("err data");
    // A periodic interrupt never coincides with an error.
    a_fire: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && rsp.rtc_irq |-> !rsp.access_error) else $error("fire with error");
    // A held result stays stable while stalled.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp)) else $error("unstable");
endmodule

bind legacy_io_pic_pit_rtc_block lio_checker u_lio_checker (
    .i_clk(i_clk),
    .i_rst_n(i_rst_n),
    .req_valid(i_req.valid),
    .req_ready(i_req.ready),
    .rsp_valid(o_rsp.valid),
    .rsp_ready(o_rsp.ready),
    .rsp(o_rsp.data)
);
